// ----- sv/radial_brush_pixel_blend_top_assert.svh -----
// Assertion macros for the radial brush blend block.
// Included by the RTL modules that check their own pipeline; expects clock and reset in scope.
`ifndef RADIAL_BRUSH_PIXEL_BLEND_TOP_ASSERT_SVH
`define RADIAL_BRUSH_PIXEL_BLEND_TOP_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define RBPB_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define RBPB_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rbpb_pkg.sv -----
// Shared types, codes and constants of the radial brush blend block.
// Holds the elaboration-time sigmoid table builder; depends on nothing.
package rbpb_pkg;

   // Field and port widths
   localparam int PIX_BITS       = 8;
   localparam int SCALE_BITS     = 16;
   localparam int STRENGTH_BITS  = 14;
   localparam int MODE_BITS      = 2;
   localparam int SIG_BITS       = 13;
   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef logic [MODE_BITS-1:0]            mode_type;
   typedef logic [CSR_INDEX_BITS-1:0]       csr_index_type;
   typedef logic signed [STRENGTH_BITS-1:0] weight_type;

   // Register indexes
   localparam csr_index_type CSR_CENTER_X      = 3'd0;
   localparam csr_index_type CSR_CENTER_Y      = 3'd1;
   localparam csr_index_type CSR_FALLOFF_SCALE = 3'd2;
   localparam csr_index_type CSR_STRENGTH      = 3'd3;
   localparam csr_index_type CSR_BLEND_MODE    = 3'd4;

   // Blend modes; the unused code behaves as fill
   localparam mode_type MODE_IMAGE = 2'd0;
   localparam mode_type MODE_HILLS = 2'd1;
   localparam mode_type MODE_FILL  = 2'd2;

   // Reset values
   localparam logic [SCALE_BITS-1:0] SCALE_RESET    = 16'd4096;
   localparam weight_type            STRENGTH_RESET = 14'sd4096;

   // Fixed point: Q.12 weights and distance, Q.24 blend accumulator
   localparam int Q_FRAC        = 12;
   localparam int ACC_FRAC      = 2 * Q_FRAC;
   localparam int SIG_SPAN_BITS = 16;
   // 6.0 + 8.0 in Q.12: shifts d onto the table span [-8, 8)
   localparam int D_TABLE_OFFSET = 57344;

   localparam weight_type K_OFFSET_IMAGE = 14'sd41;
   localparam weight_type K_OFFSET_OTHER = 14'sd410;

   localparam logic signed [PIX_BITS:0] HILLS_STEP = 9'sd5;
   localparam logic signed [PIX_BITS:0] FILL_FULL  = 9'sd255;
   localparam logic signed [PIX_BITS:0] FILL_EMPTY = 9'sd0;
   localparam int PIX_MAX = 255;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // Restoring long division, used only while elaborating the table.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^(-y), y in Q.30 within [0, 8]: Taylor series at y/8, squared three times.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
      logic [63:0] z;
      logic [63:0] sum;
      logic [63:0] term;
      z    = y >> 3;
      sum  = Q30_ONE;
      term = Q30_ONE;
      for (int n = 1; n <= 16; n++) begin
         term = udiv64((term * z) >> 30, 64'(n));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (int i = 0; i < 3; i++) begin
         sum = (sum * sum) >> 30;
      end
      return sum;
   endfunction

   // Sigmoid at d = -8 + 16*idx/entries, Q.12, rounded to nearest.
   function automatic logic [SIG_BITS-1:0] sig_entry(input int idx, input int entries);
      logic [63:0] off;
      logic        neg;
      logic [63:0] mag;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      off = udiv64(64'(idx) * 64'd65536, 64'(entries));
      neg = off < 64'd32768;
      mag = neg ? 64'd32768 - off : off - 64'd32768;
      e   = exp_neg_q30(mag << 18);
      den = Q30_ONE + e;
      num = neg ? (e << 12) : (64'd1 << 42);
      return SIG_BITS'(udiv64(num + (den >> 1), den));
   endfunction

endpackage

// ----- sv/radial_brush_pixel_blend_top.sv -----
// Radial brush stamp, one pixel per beat: distance, sigmoid falloff and blend.
// Uses rbpb_pkg, rbpb_sqrt and radial_brush_pixel_blend_top_assert.svh.
//
//   channel | dir | carries
//   --------+-----+----------------------------------------------------------
//   req_    | in  | pix_x, pix_y, pixel_value, brush_value
//   rsp_    | out | new_value, touched
//   csr_    | in  | center_x, center_y, falloff_scale, strength, blend_mode
//
// Sustained rate is one beat per cycle while the rsp_ side accepts; the square
// root pipe produces two result bits per stage.
// Every stage holds a valid bit and loads when it is empty or its successor
// loads, so bubbles collapse and a stalled rsp_ side holds every beat in place.
// Reset is synchronous, clears the valid bits and loads the csr reset values.
// The user must write registers only while the pipe is drained; the block does not enforce it.
`include "radial_brush_pixel_blend_top_assert.svh"

module radial_brush_pixel_blend_top #(
   parameter int WINDOW_BITS     = 8,
   parameter int SIGMOID_ENTRIES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_ beat
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] pix_x, [15:8] pix_y, [23:16] pixel_value, [31:24] brush_value
   input  logic [rbpb_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // rsp_ beat
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] new_value
   output logic [rbpb_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [0] touched
   output logic [0:0]                          rsp_tuser,
   // register writes
   input  logic                                csr_we,
   input  logic [rbpb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rbpb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int PixW      = rbpb_pkg::PIX_BITS;
   localparam int CoordBits = (WINDOW_BITS < PixW) ? WINDOW_BITS : PixW;
   localparam int DiffW     = CoordBits + 1;
   localparam int SqW       = 2 * CoordBits + 2;
   localparam int D2W       = 2 * CoordBits + 1;
   localparam int RootRaw   = (D2W + rbpb_pkg::ACC_FRAC + 1) / 2;
   localparam int RootBits  = ((RootRaw + 1) / 2) * 2;
   localparam int RadW      = 2 * RootBits;
   localparam int MulW      = rbpb_pkg::SCALE_BITS + RootBits;
   localparam int TW        = MulW - rbpb_pkg::Q_FRAC + 1;
   localparam int IdxBits   = $clog2(SIGMOID_ENTRIES);
   localparam int IdxProdW  = rbpb_pkg::SIG_SPAN_BITS + IdxBits + 1;
   localparam int SigW      = rbpb_pkg::SIG_BITS;
   localparam int KW        = rbpb_pkg::STRENGTH_BITS;
   localparam int MW        = KW + 1;
   localparam int FW        = PixW + 1;
   localparam int WW        = KW + MW;
   localparam int PW        = FW + WW;
   localparam int CW        = PW + 2;
   localparam int ClW       = PixW + rbpb_pkg::ACC_FRAC;
   localparam logic signed [CW-1:0] CMax = CW'(rbpb_pkg::PIX_MAX) <<< rbpb_pkg::ACC_FRAC;

   // ---------------------------------------------------------------- registers
   logic [PixW-1:0]                     center_x_ff;
   logic [PixW-1:0]                     center_y_ff;
   logic [rbpb_pkg::SCALE_BITS-1:0]     scale_ff;
   rbpb_pkg::weight_type                strength_ff;
   rbpb_pkg::mode_type                  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         scale_ff    <= rbpb_pkg::SCALE_RESET;
         strength_ff <= rbpb_pkg::STRENGTH_RESET;
         mode_ff     <= rbpb_pkg::MODE_IMAGE;
      end else if (csr_we) begin
         unique case (csr_index)
            rbpb_pkg::CSR_CENTER_X:      center_x_ff <= csr_wdata[PixW-1:0];
            rbpb_pkg::CSR_CENTER_Y:      center_y_ff <= csr_wdata[PixW-1:0];
            rbpb_pkg::CSR_FALLOFF_SCALE: scale_ff    <= csr_wdata;
            rbpb_pkg::CSR_STRENGTH:      strength_ff <= csr_wdata[KW-1:0];
            rbpb_pkg::CSR_BLEND_MODE:    mode_ff     <= csr_wdata[rbpb_pkg::MODE_BITS-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- stall chain
   // A stage loads when it is empty or the stage after it loads.
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, out_vld_ff;
   logic ld0, ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;
   logic sq_in_ready, sq_out_valid;

   assign ld_out     = !out_vld_ff || rsp_tready;
   assign ld7        = !v7_ff || ld_out;
   assign ld6        = !v6_ff || ld7;
   assign ld5        = !v5_ff || ld6;
   assign ld4        = !v4_ff || ld5;
   assign ld3        = !v3_ff || ld4;
   assign ld2        = !v2_ff || ld3;
   assign ld1        = !v1_ff || sq_in_ready;
   assign ld0        = !v0_ff || ld1;
   assign req_tready = ld0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         v7_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (ld0)    v0_ff      <= req_tvalid;
         if (ld1)    v1_ff      <= v0_ff;
         if (ld2)    v2_ff      <= sq_out_valid;
         if (ld3)    v3_ff      <= v2_ff;
         if (ld4)    v4_ff      <= v3_ff;
         if (ld5)    v5_ff      <= v4_ff;
         if (ld6)    v6_ff      <= v5_ff;
         if (ld7)    v7_ff      <= v6_ff;
         if (ld_out) out_vld_ff <= v7_ff;
      end
   end

   // ---------------------------------------------------------------- stage 0
   // Offsets from the brush center, coordinates masked to the window.
   logic [PixW-1:0]         pix_x, pix_y, pix_val, brush_val;
   logic signed [DiffW-1:0] dx_in, dy_in, dx0_ff, dy0_ff;
   logic [PixW-1:0]         p0_ff, q0_ff;

   assign pix_x     = req_tdata[PixW-1:0];
   assign pix_y     = req_tdata[2*PixW-1:PixW];
   assign pix_val   = req_tdata[3*PixW-1:2*PixW];
   assign brush_val = req_tdata[4*PixW-1:3*PixW];

   assign dx_in = $signed({1'b0, pix_x[CoordBits-1:0]}) - $signed({1'b0, center_x_ff[CoordBits-1:0]});
   assign dy_in = $signed({1'b0, pix_y[CoordBits-1:0]}) - $signed({1'b0, center_y_ff[CoordBits-1:0]});

   always_ff @(posedge clock) begin
      if (ld0) begin
         dx0_ff <= dx_in;
         dy0_ff <= dy_in;
         p0_ff  <= pix_val;
         q0_ff  <= brush_val;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Squared distance.
   logic signed [SqW-1:0] dx_ext, dy_ext, sq_x, sq_y;
   logic [D2W-1:0]        d2_in, d2_ff;
   logic [PixW-1:0]       p1_ff, q1_ff;

   assign dx_ext = SqW'(dx0_ff);
   assign dy_ext = SqW'(dy0_ff);
   assign sq_x   = dx_ext * dx_ext;
   assign sq_y   = dy_ext * dy_ext;
   assign d2_in  = D2W'(sq_x + sq_y);

   always_ff @(posedge clock) begin
      if (ld1) begin
         d2_ff <= d2_in;
         p1_ff <= p0_ff;
         q1_ff <= q0_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   // Distance in Q.12 is the root of d2 shifted up by 24.
   logic [RootBits-1:0] sq_root;
   logic [2*PixW-1:0]   sq_side;

   rbpb_sqrt #(
      .ROOT_BITS (RootBits),
      .SIDE_BITS (2 * PixW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (RadW'({d2_ff, {rbpb_pkg::ACC_FRAC{1'b0}}})),
      .in_side   ({p1_ff, q1_ff}),
      .out_valid (sq_out_valid),
      .out_ready (ld2),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------------------------------------------------------- stage 2
   // Scale the distance.
   logic [MulW-1:0] mul_in, mul2_ff;
   logic [PixW-1:0] p2_ff, q2_ff;

   assign mul_in = MulW'(scale_ff) * MulW'(sq_root);

   always_ff @(posedge clock) begin
      if (ld2) begin
         mul2_ff <= mul_in;
         p2_ff   <= sq_side[2*PixW-1:PixW];
         q2_ff   <= sq_side[PixW-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Round to Q.12, shift d onto the table span and pick the entry.
   logic [MulW:0]         t_rnd;
   logic [TW-1:0]         t_val, t_diff;
   logic                  t_far;
   logic [IdxProdW-1:0]   idx_prod;
   logic [IdxBits:0]      idx_raw;
   logic [IdxBits-1:0]    idx_in, idx3_ff;
   logic [PixW-1:0]       p3_ff, q3_ff;

   assign t_rnd    = {1'b0, mul2_ff} + (MulW+1)'(1 << (rbpb_pkg::Q_FRAC - 1));
   assign t_val    = t_rnd[MulW:rbpb_pkg::Q_FRAC];
   assign t_far    = t_val > TW'(rbpb_pkg::D_TABLE_OFFSET);
   assign t_diff   = TW'(rbpb_pkg::D_TABLE_OFFSET) - t_val;
   assign idx_prod = IdxProdW'(t_diff[rbpb_pkg::SIG_SPAN_BITS-1:0]) * IdxProdW'(SIGMOID_ENTRIES);
   assign idx_raw  = idx_prod[IdxProdW-1:rbpb_pkg::SIG_SPAN_BITS];

   always_comb begin
      if (t_far) begin
         idx_in = '0;
      end else if (idx_raw > (IdxBits+1)'(SIGMOID_ENTRIES - 1)) begin
         idx_in = IdxBits'(SIGMOID_ENTRIES - 1);
      end else begin
         idx_in = idx_raw[IdxBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld3) begin
         idx3_ff <= idx_in;
         p3_ff   <= p2_ff;
         q3_ff   <= q2_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Sigmoid lookup, table fixed at elaboration.
   logic [SigW-1:0] sig_rom [SIGMOID_ENTRIES];
   logic [SigW-1:0] ent4_ff;
   logic [PixW-1:0] p4_ff, q4_ff;

   for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_sig
      localparam logic [SigW-1:0] Entry = rbpb_pkg::sig_entry(g, SIGMOID_ENTRIES);
      assign sig_rom[g] = Entry;
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         ent4_ff <= sig_rom[idx3_ff];
         p4_ff   <= p3_ff;
         q4_ff   <= q3_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // Falloff k, blend weight operand and blend direction.
   logic signed [KW-1:0] k_in;
   logic                 hit_in;
   logic signed [MW-1:0] s_ext, s_mag, m_in;
   logic                 s_pos;
   logic signed [FW-1:0] f_in;
   logic signed [KW-1:0] k5_ff;
   logic signed [MW-1:0] m5_ff;
   logic signed [FW-1:0] f5_ff;
   logic                 hit5_ff;
   logic [PixW-1:0]      p5_ff;

   assign k_in   = $signed({1'b0, ent4_ff}) -
                   ((mode_ff == rbpb_pkg::MODE_IMAGE) ? rbpb_pkg::K_OFFSET_IMAGE
                                                      : rbpb_pkg::K_OFFSET_OTHER);
   assign hit_in = k_in > $signed(KW'(0));
   assign s_ext  = MW'(strength_ff);
   assign s_mag  = strength_ff[KW-1] ? -s_ext : s_ext;
   assign s_pos  = !strength_ff[KW-1] && (strength_ff != '0);
   assign m_in   = (mode_ff == rbpb_pkg::MODE_IMAGE) ? s_ext : s_mag;

   always_comb begin
      unique case (mode_ff)
         rbpb_pkg::MODE_IMAGE: f_in = $signed({1'b0, q4_ff}) - $signed({1'b0, p4_ff});
         rbpb_pkg::MODE_HILLS: f_in = s_pos ? -rbpb_pkg::HILLS_STEP : rbpb_pkg::HILLS_STEP;
         default: f_in = (s_pos ? rbpb_pkg::FILL_FULL : rbpb_pkg::FILL_EMPTY) -
                         $signed({1'b0, p4_ff});  // fill, and the spare code
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld5) begin
         k5_ff   <= k_in;
         m5_ff   <= m_in;
         f5_ff   <= f_in;
         hit5_ff <= hit_in;
         p5_ff   <= p4_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6
   // Weight w = k * strength (its magnitude outside image mode), Q.24.
   logic signed [WW-1:0] w_in, w6_ff;
   logic signed [FW-1:0] f6_ff;
   logic                 hit6_ff;
   logic [PixW-1:0]      p6_ff;

   assign w_in = WW'(k5_ff) * WW'(m5_ff);

   always_ff @(posedge clock) begin
      if (ld6) begin
         w6_ff   <= w_in;
         f6_ff   <= f5_ff;
         hit6_ff <= hit5_ff;
         p6_ff   <= p5_ff;
      end
   end

   // ---------------------------------------------------------------- stage 7
   // Step toward the target.
   logic signed [PW-1:0] prod_in, prod7_ff;
   logic                 hit7_ff;
   logic [PixW-1:0]      p7_ff;

   assign prod_in = PW'(f6_ff) * PW'(w6_ff);

   always_ff @(posedge clock) begin
      if (ld7) begin
         prod7_ff <= prod_in;
         hit7_ff  <= hit6_ff;
         p7_ff    <= p6_ff;
      end
   end

   // ---------------------------------------------------------------- output
   // Add to the pixel, clamp to 0..255, round half up; untouched pixels pass.
   logic signed [CW-1:0] c_sum;
   logic [ClW-1:0]       c_clamp, c_rnd;
   logic [PixW-1:0]      new_in;
   logic [PixW-1:0]      new_ff;
   logic                 touched_ff;

   assign c_sum = $signed({{(CW-ClW){1'b0}}, p7_ff, {rbpb_pkg::ACC_FRAC{1'b0}}}) + CW'(prod7_ff);

   always_comb begin
      if (c_sum < $signed(CW'(0))) begin
         c_clamp = '0;
      end else if (c_sum > CMax) begin
         c_clamp = CMax[ClW-1:0];
      end else begin
         c_clamp = c_sum[ClW-1:0];
      end
   end

   assign c_rnd  = c_clamp + ClW'(1 << (rbpb_pkg::ACC_FRAC - 1));
   assign new_in = hit7_ff ? c_rnd[ClW-1:rbpb_pkg::ACC_FRAC] : p7_ff;

   always_ff @(posedge clock) begin
      if (ld_out) begin
         new_ff     <= new_in;
         touched_ff <= hit7_ff;
      end
   end

   assign rsp_tvalid   = out_vld_ff;
   assign rsp_tdata    = new_ff;
   assign rsp_tuser[0] = touched_ff;

   `RBPB_CHECK_NOW(a_reset_empty, $past(reset), !rsp_tvalid, "result beat right after reset")
   `RBPB_CHECK_NOW(a_free_when_drained, !rsp_tvalid, req_tready, "input stalled while output empty")
   `RBPB_CHECK_NEXT(a_pass_through, v7_ff && ld_out && !hit7_ff, rsp_tvalid && !rsp_tuser[0] && rsp_tdata == $past(p7_ff), "untouched pixel changed")

endmodule

// ----- sv/rbpb_sqrt.sv -----
// Pipelined digit-by-digit integer square root, two result bits per stage.
// Carries a side payload alongside; uses radial_brush_pixel_blend_top_assert.svh.
`include "radial_brush_pixel_blend_top_assert.svh"

module rbpb_sqrt #(
   parameter int ROOT_BITS = 22,
   parameter int SIDE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2*ROOT_BITS-1:0] in_rad,
   input  logic [SIDE_BITS-1:0]   in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ROOT_BITS-1:0]   out_root,
   output logic [SIDE_BITS-1:0]   out_side
);

   localparam int Stages = ROOT_BITS / 2;
   localparam int RadW   = 2 * ROOT_BITS;
   localparam int RemW   = ROOT_BITS + 2;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_src;
   logic [Stages:0]   ld;

   logic [RemW-1:0]      rem_ff   [Stages];
   logic [RemW-1:0]      rem_in   [Stages];
   logic [RemW-1:0]      rem_src  [Stages];
   logic [ROOT_BITS-1:0] root_ff  [Stages];
   logic [ROOT_BITS-1:0] root_in  [Stages];
   logic [ROOT_BITS-1:0] root_src [Stages];
   logic [RadW-1:0]      rad_ff   [Stages];
   logic [RadW-1:0]      rad_in   [Stages];
   logic [RadW-1:0]      rad_src  [Stages];
   logic [SIDE_BITS-1:0] side_ff  [Stages];
   logic [SIDE_BITS-1:0] side_src [Stages];

   assign ld[Stages] = out_ready;
   assign in_ready   = ld[0];

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign vld_src[g]  = in_valid;
         assign rem_src[g]  = '0;
         assign root_src[g] = '0;
         assign rad_src[g]  = in_rad;
         assign side_src[g] = in_side;
      end else begin : g_next
         assign vld_src[g]  = vld_ff[g-1];
         assign rem_src[g]  = rem_ff[g-1];
         assign root_src[g] = root_ff[g-1];
         assign rad_src[g]  = rad_ff[g-1];
         assign side_src[g] = side_ff[g-1];
      end

      assign ld[g] = !vld_ff[g] || ld[g+1];

      always_comb begin
         logic [RemW-1:0]      rem;
         logic [RemW-1:0]      trial;
         logic [ROOT_BITS-1:0] root;
         logic [RadW-1:0]      rad;
         rem  = rem_src[g];
         root = root_src[g];
         rad  = rad_src[g];
         for (int j = 0; j < 2; j++) begin
            rem   = {rem[RemW-3:0], rad[RadW-1 -: 2]};
            trial = {root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[ROOT_BITS-2:0], 1'b1};
            end else begin
               root = {root[ROOT_BITS-2:0], 1'b0};
            end
            rad = {rad[RadW-3:0], 2'b00};
         end
         rem_in[g]  = rem;
         root_in[g] = root;
         rad_in[g]  = rad;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (ld[g]) begin
            vld_ff[g] <= vld_src[g];
         end
      end

      always_ff @(posedge clock) begin
         if (ld[g]) begin
            rem_ff[g]  <= rem_in[g];
            root_ff[g] <= root_in[g];
            rad_ff[g]  <= rad_in[g];
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

   `RBPB_CHECK_NOW(a_sqrt_ready_chain, out_ready, in_ready, "sqrt stalls input with output free")
   `RBPB_CHECK_NEXT(a_sqrt_hold, out_valid && !out_ready, out_valid && out_root == $past(out_root), "sqrt dropped a stalled root")

endmodule
